FILE: rtl/sts_hp_pkg.sv
// ----------------------------------------------------------------------------
// sts_hp_pkg
// Shared types and constants for the Strict-Transport-Security header parser.
// ----------------------------------------------------------------------------
package sts_hp_pkg;

	localparam int AGE_W      = 40;
	localparam int NAME_CNT_W = 5;

	// Directive name lengths and the saturation point of the name counter
	localparam logic [NAME_CNT_W-1:0] AGE_LEN      = 5'd7;
	localparam logic [NAME_CNT_W-1:0] SUB_LEN      = 5'd17;
	localparam logic [NAME_CNT_W-1:0] NAME_CNT_MAX = 5'd31;

	// Character codes
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Name-side state of the directive being parsed
	typedef struct packed {
		logic                  in_value;
		logic [NAME_CNT_W-1:0] name_cnt;
		logic                  may_age;
		logic                  may_sub;
		logic                  name_sp;
	} name_state_t;

	// State that lives across directives of one header
	typedef struct packed {
		logic             age_seen;
		logic [AGE_W-1:0] age_val;
		logic             sub_seen;
		logic             rejected;
	} hdr_state_t;

	localparam name_state_t NAME_RESET = '{
		in_value: 1'b0, name_cnt: '0, may_age: 1'b1, may_sub: 1'b1, name_sp: 1'b0};
	localparam hdr_state_t HDR_RESET = '{
		age_seen: 1'b0, age_val: '0, sub_seen: 1'b0, rejected: 1'b0};

	// Lower-case letters of "max-age" by position
	function automatic logic [7:0] age_char(input logic [NAME_CNT_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0: ch = 8'h6D; // m
			5'd1: ch = 8'h61; // a
			5'd2: ch = 8'h78; // x
			5'd3: ch = 8'h2D; // -
			5'd4: ch = 8'h61; // a
			5'd5: ch = 8'h67; // g
			5'd6: ch = 8'h65; // e
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Lower-case letters of "includesubdomains" by position
	function automatic logic [7:0] sub_char(input logic [NAME_CNT_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:  ch = 8'h69; // i
			5'd1:  ch = 8'h6E; // n
			5'd2:  ch = 8'h63; // c
			5'd3:  ch = 8'h6C; // l
			5'd4:  ch = 8'h75; // u
			5'd5:  ch = 8'h64; // d
			5'd6:  ch = 8'h65; // e
			5'd7:  ch = 8'h73; // s
			5'd8:  ch = 8'h75; // u
			5'd9:  ch = 8'h62; // b
			5'd10: ch = 8'h64; // d
			5'd11: ch = 8'h6F; // o
			5'd12: ch = 8'h6D; // m
			5'd13: ch = 8'h61; // a
			5'd14: ch = 8'h69; // i
			5'd15: ch = 8'h6E; // n
			5'd16: ch = 8'h73; // s
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

endpackage

FILE: rtl/sts_hp_step.sv
// ----------------------------------------------------------------------------
// sts_hp_step
// Next-state logic for one header byte: name match, digit accumulation,
// directive close and the verdict of the header on its last byte.
// ----------------------------------------------------------------------------
module sts_hp_step
	import sts_hp_pkg::*;
#(
	parameter int MAX_DIGITS = 12,
	localparam int DCW = $clog2(MAX_DIGITS + 2)
) (
	input  logic [7:0]       header_byte,
	input  logic             last_byte,
	input  name_state_t      name_cur,
	input  logic [DCW-1:0]   dig_cnt_cur,
	input  logic [AGE_W-1:0] acc_cur,
	input  logic             not_dig_cur,
	input  logic             val_sp_cur,
	input  hdr_state_t       hdr_cur,
	output name_state_t      name_nxt,
	output logic [DCW-1:0]   dig_cnt_nxt,
	output logic [AGE_W-1:0] acc_nxt,
	output logic             not_dig_nxt,
	output logic             val_sp_nxt,
	output hdr_state_t       hdr_nxt,
	output logic             verdict_ok
);

	localparam logic [DCW-1:0] MAX_DIG = DCW'(MAX_DIGITS);

	logic       is_semi;
	logic       blank;
	logic       is_digit;
	logic [7:0] lc;
	logic [AGE_W-1:0] acc_mac;

	// Directive state seen by the close logic
	name_state_t      end_name;
	logic [DCW-1:0]   end_dig_cnt;
	logic [AGE_W-1:0] end_acc;
	logic             end_not_dig;
	logic             do_end;

	assign is_semi  = (header_byte == CH_SEMI);
	assign blank    = is_blank(header_byte);
	assign is_digit = (header_byte >= CH_0) && (header_byte <= CH_9);
	assign lc = ((header_byte >= CH_UC_A) && (header_byte <= CH_UC_Z)) ?
		header_byte + CASE_OFS : header_byte;
	assign acc_mac = (acc_cur << 3) + (acc_cur << 1) + {{(AGE_W-4){1'b0}}, header_byte[3:0]};

	// Per-byte update of the directive being parsed
	always_comb begin
		name_nxt    = name_cur;
		dig_cnt_nxt = dig_cnt_cur;
		acc_nxt     = acc_cur;
		not_dig_nxt = not_dig_cur;
		val_sp_nxt  = val_sp_cur;
		if (is_semi) begin
			name_nxt    = NAME_RESET;
			dig_cnt_nxt = '0;
			acc_nxt     = '0;
			not_dig_nxt = 1'b0;
			val_sp_nxt  = 1'b0;
		end else if (!name_cur.in_value && header_byte == CH_EQ) begin
			name_nxt.in_value = 1'b1;
		end else if (name_cur.in_value) begin
			if (blank) begin
				if (dig_cnt_cur != '0 || not_dig_cur)
					val_sp_nxt = 1'b1;
			end else if (val_sp_cur || !is_digit) begin
				not_dig_nxt = 1'b1;
			end else begin
				if (dig_cnt_cur < MAX_DIG)
					acc_nxt = acc_mac;
				if (dig_cnt_cur <= MAX_DIG)
					dig_cnt_nxt = dig_cnt_cur + 1'b1;
			end
		end else begin
			if (blank) begin
				if (name_cur.name_cnt != '0)
					name_nxt.name_sp = 1'b1;
			end else begin
				if (name_cur.name_sp) begin
					name_nxt.may_age = 1'b0;
					name_nxt.may_sub = 1'b0;
				end
				if (!(name_cur.name_cnt < AGE_LEN && age_char(name_cur.name_cnt) == lc))
					name_nxt.may_age = 1'b0;
				if (!(name_cur.name_cnt < SUB_LEN && sub_char(name_cur.name_cnt) == lc))
					name_nxt.may_sub = 1'b0;
				if (name_cur.name_cnt < NAME_CNT_MAX)
					name_nxt.name_cnt = name_cur.name_cnt + 1'b1;
			end
		end
	end

	// Directive close: on ';' it sees the old directive; on the last byte the
	// updated one. A ';' that is also last closes once, the rest is empty.
	assign do_end      = is_semi || last_byte;
	assign end_name    = is_semi ? name_cur    : name_nxt;
	assign end_dig_cnt = is_semi ? dig_cnt_cur : dig_cnt_nxt;
	assign end_acc     = is_semi ? acc_cur     : acc_nxt;
	assign end_not_dig = is_semi ? not_dig_cur : not_dig_nxt;

	always_comb begin
		hdr_nxt = hdr_cur;
		if (do_end) begin
			if (end_name.may_age && end_name.name_cnt == AGE_LEN) begin
				if (end_name.in_value && end_dig_cnt != '0 && end_dig_cnt <= MAX_DIG &&
						!end_not_dig) begin
					hdr_nxt.age_seen = 1'b1;
					hdr_nxt.age_val  = end_acc;
				end else begin
					hdr_nxt.rejected = 1'b1;
				end
			end else if (end_name.may_sub && end_name.name_cnt == SUB_LEN) begin
				hdr_nxt.sub_seen = 1'b1;
			end
		end
	end

	assign verdict_ok = hdr_nxt.age_seen && !hdr_nxt.rejected;

endmodule

FILE: rtl/sts_header_parser_unit.sv
// ----------------------------------------------------------------------------
// sts_header_parser_unit
// Strict-Transport-Security header value parser, one byte per transfer,
// one verdict per header on its last byte.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------
//  byte     | byte_valid / byte_ready      | header_byte, last_byte
//  verdict  | verdict_valid / verdict_ready| header_valid, max_age,
//           |                              | include_subdomains
//
//  One byte per cycle while byte_ready is high; the parse state updates in the cycle of the transfer.
//  The verdict appears in the output register in the cycle after the last byte.
//  Reset clears the parse state and the output valid.
//  A waiting verdict blocks a byte transfer only if verdict_ready is low.
// ----------------------------------------------------------------------------
module sts_header_parser_unit
	import sts_hp_pkg::*;
#(
	parameter int MAX_DIGITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  logic [7:0]       header_byte,
	input  logic             last_byte,
	output logic             verdict_valid,
	input  logic             verdict_ready,
	output logic             header_valid,
	output logic [AGE_W-1:0] max_age,
	output logic             include_subdomains
);

	localparam int DCW = $clog2(MAX_DIGITS + 2);

	name_state_t      name_q,    name_nxt;
	logic [DCW-1:0]   dig_cnt_q, dig_cnt_nxt;
	logic [AGE_W-1:0] acc_q,     acc_nxt;
	logic             not_dig_q, not_dig_nxt;
	logic             val_sp_q,  val_sp_nxt;
	hdr_state_t       hdr_q,     hdr_nxt;
	logic             verdict_ok;
	logic             out_valid_q;
	logic             take;

	assign byte_ready = !out_valid_q || verdict_ready;
	assign take       = byte_valid && byte_ready;

	sts_hp_step #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_step (
		.header_byte (header_byte),
		.last_byte   (last_byte),
		.name_cur    (name_q),
		.dig_cnt_cur (dig_cnt_q),
		.acc_cur     (acc_q),
		.not_dig_cur (not_dig_q),
		.val_sp_cur  (val_sp_q),
		.hdr_cur     (hdr_q),
		.name_nxt    (name_nxt),
		.dig_cnt_nxt (dig_cnt_nxt),
		.acc_nxt     (acc_nxt),
		.not_dig_nxt (not_dig_nxt),
		.val_sp_nxt  (val_sp_nxt),
		.hdr_nxt     (hdr_nxt),
		.verdict_ok  (verdict_ok)
	);

	// Parse state: advances on each byte transfer, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q    <= NAME_RESET;
			dig_cnt_q <= '0;
			acc_q     <= '0;
			not_dig_q <= 1'b0;
			val_sp_q  <= 1'b0;
			hdr_q     <= HDR_RESET;
		end else if (take) begin
			if (last_byte) begin
				name_q    <= NAME_RESET;
				dig_cnt_q <= '0;
				acc_q     <= '0;
				not_dig_q <= 1'b0;
				val_sp_q  <= 1'b0;
				hdr_q     <= HDR_RESET;
			end else begin
				name_q    <= name_nxt;
				dig_cnt_q <= dig_cnt_nxt;
				acc_q     <= acc_nxt;
				not_dig_q <= not_dig_nxt;
				val_sp_q  <= val_sp_nxt;
				hdr_q     <= hdr_nxt;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Verdict payload, zero when the header is invalid
	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			header_valid       <= verdict_ok;
			max_age            <= verdict_ok ? hdr_nxt.age_val : '0;
			include_subdomains <= verdict_ok && hdr_nxt.sub_seen;
		end
	end

	assign verdict_valid = out_valid_q;

endmodule
